@@ design/rbs_pkg.sv @@
package rbs_pkg;

  localparam int NUM_LANES = 3;
  localparam int DIV_STEPS = 32;
  localparam int LANE_LAT = DIV_STEPS + 3;
  localparam int PIPE_LAT = LANE_LAT + 1;

  localparam logic [31:0] NEAR_ZERO_RAW = 32'd10738;
  localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic near;
    logic ok;
    logic signed [31:0] t_in;
    logic signed [31:0] t_out;
  } lane_res_t;

endpackage

@@ design/rbs_div_pipe.sv @@
module rbs_div_pipe import rbs_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] num_mag,
  input  logic [31:0] den,
  output logic [31:0] quo,
  output logic        ovf
);

  // quotient of num_mag * 2^30 by den, one bit per stage
  logic [31:0] rem_r [0:DIV_STEPS];
  logic [31:0] quo_r [0:DIV_STEPS];
  logic [31:0] den_r [0:DIV_STEPS];
  logic [1:0]  lo_r  [0:DIV_STEPS];
  logic        ovf_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, num_mag[32:2]};
      quo_r[0] <= '0;
      den_r[0] <= den;
      lo_r[0]  <= num_mag[1:0];
      ovf_r[0] <= {1'b0, num_mag[32:2]} >= den;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    localparam int BI = DIV_STEPS - k;
    logic        bit_in;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign bit_in = (BI == 31) ? lo_r[k-1][1] : ((BI == 30) ? lo_r[k-1][0] : 1'b0);
    assign trial  = {rem_r[k-1], bit_in};
    assign diff   = trial - {1'b0, den_r[k-1]};
    assign ge     = trial >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[31:0] : trial[31:0];
        quo_r[k] <= {quo_r[k-1][30:0], ge};
        den_r[k] <= den_r[k-1];
        lo_r[k]  <= lo_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quo = quo_r[DIV_STEPS];
  assign ovf = ovf_r[DIV_STEPS];

endmodule

@@ design/rbs_axis_lane.sv @@
module rbs_axis_lane import rbs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] origin,
  input  logic signed [31:0] dir,
  input  logic [30:0]        half,
  output lane_res_t          res
);

  logic signed [33:0] h34, o34, n1, n2;
  logic [31:0] dmag;
  logic [32:0] mag1, mag2;

  logic [32:0] mag1_r, mag2_r;
  logic [31:0] dmag_r;
  logic        neg1_r, neg2_r, near_r, ok_r;

  // side bits: neg1, neg2, near, ok
  logic [3:0]  side_r [0:DIV_STEPS];
  logic [31:0] q1, q2;
  logic        ov1, ov2;
  logic signed [31:0] t1, t2;
  lane_res_t   res_r;

  assign h34  = {3'b000, half};
  assign o34  = {{2{origin[31]}}, origin};
  assign n1   = -h34 - o34;
  assign n2   = h34 - o34;
  assign dmag = dir[31] ? (~dir + 32'd1) : dir;
  assign mag1 = n1[33] ? 33'(-n1) : n1[32:0];
  assign mag2 = n2[33] ? 33'(-n2) : n2[32:0];

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r <= mag1;
      mag2_r <= mag2;
      dmag_r <= dmag;
      neg1_r <= n1[33] ^ dir[31];
      neg2_r <= n2[33] ^ dir[31];
      near_r <= dmag < NEAR_ZERO_RAW;
      ok_r   <= !(o34 < -h34 || o34 > h34);
    end
  end

  rbs_div_pipe u_div_lo (
    .clk(clk), .en(en), .num_mag(mag1_r), .den(dmag_r), .quo(q1), .ovf(ov1)
  );

  rbs_div_pipe u_div_hi (
    .clk(clk), .en(en), .num_mag(mag2_r), .den(dmag_r), .quo(q2), .ovf(ov2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= {neg1_r, neg2_r, near_r, ok_r};
      for (int i = 1; i <= DIV_STEPS; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  function automatic logic signed [31:0] sat_t(input logic [31:0] q, input logic ov,
                                               input logic neg);
    logic signed [31:0] r;
    if (ov) begin
      r = neg ? T_MIN : T_MAX;
    end else if (neg) begin
      r = (q > 32'h8000_0000) ? T_MIN : -$signed(q);
    end else begin
      r = q[31] ? T_MAX : $signed(q);
    end
    return r;
  endfunction

  assign t1 = sat_t(q1, ov1, side_r[DIV_STEPS][3]);
  assign t2 = sat_t(q2, ov2, side_r[DIV_STEPS][2]);

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.near  <= side_r[DIV_STEPS][1];
      res_r.ok    <= side_r[DIV_STEPS][0];
      res_r.t_in  <= (t1 > t2) ? t2 : t1;
      res_r.t_out <= (t1 > t2) ? t1 : t2;
    end
  end

  assign res = res_r;

endmodule

@@ design/rbs_merge.sv @@
module rbs_merge import rbs_pkg::*; (
  input  logic                          clk,
  input  logic                          en,
  input  lane_res_t [NUM_LANES-1:0]     res,
  input  logic [30:0]                   maxd,
  output logic                          hit
);

  logic signed [31:0] tmin, tmax, dmax;
  logic all_ok;
  logic hit_r;

  assign dmax = $signed({1'b0, maxd});

  always_comb begin
    tmin   = '0;
    tmax   = dmax;
    all_ok = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (res[i].near) begin
        all_ok = all_ok & res[i].ok;
      end else begin
        if (res[i].t_in > tmin) tmin = res[i].t_in;
        if (res[i].t_out < tmax) tmax = res[i].t_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= all_ok && (tmin <= tmax) && (tmax >= 0) && (tmin <= dmax);
    end
  end

  assign hit = hit_r;

endmodule

@@ design/ray_box_slab_test_core.sv @@
// Ray against centered axis-aligned box, slab method in fixed point. One word
// is taken per cycle while the result side does not stall; three axis lanes
// each run two pipelined dividers for the slab parameters, and one merge
// stage narrows the interval. A stall on the result side freezes the whole
// pipeline and is passed back to in_stall the same cycle.
module ray_box_slab_test_core import rbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic [30:0]        in_half_x,
  input  logic [30:0]        in_half_y,
  input  logic [30:0]        in_half_z,
  input  logic [30:0]        in_max_dist,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit
);

  logic en;
  logic [PIPE_LAT-1:0] vld_r;
  logic [30:0] maxd_r [0:LANE_LAT-1];
  lane_res_t [NUM_LANES-1:0] lane_res;

  assign out_valid = vld_r[PIPE_LAT-1];
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      maxd_r[0] <= in_max_dist;
      for (int i = 1; i < LANE_LAT; i++) begin
        maxd_r[i] <= maxd_r[i-1];
      end
    end
  end

  rbs_axis_lane u_lane_x (
    .clk(clk), .en(en), .origin(in_origin_x), .dir(in_dir_x), .half(in_half_x),
    .res(lane_res[0])
  );

  rbs_axis_lane u_lane_y (
    .clk(clk), .en(en), .origin(in_origin_y), .dir(in_dir_y), .half(in_half_y),
    .res(lane_res[1])
  );

  rbs_axis_lane u_lane_z (
    .clk(clk), .en(en), .origin(in_origin_z), .dir(in_dir_z), .half(in_half_z),
    .res(lane_res[2])
  );

  rbs_merge u_merge (
    .clk(clk), .en(en), .res(lane_res), .maxd(maxd_r[LANE_LAT-1]), .hit(out_hit)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted word not tracked");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

endmodule

@@ bench/ray_box_slab_test_core_chk.sv @@
module ray_box_slab_test_core_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic [30:0]        in_half_x,
  input  logic [30:0]        in_half_y,
  input  logic [30:0]        in_half_z,
  input  logic [30:0]        in_max_dist,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  bit hit_q[$];

  function automatic longint clamp_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit ray_hits(logic signed [31:0] org[3], logic signed [31:0] dir[3],
                                  logic [30:0] half[3], logic [30:0] maxd);
    longint lo, hi, o, d, h, a, b, s;
    lo = 0;
    hi = maxd;
    for (int i = 0; i < 3; i++) begin
      o = org[i];
      d = dir[i];
      h = half[i];
      if ((d < 0 ? -d : d) < rbs_pkg::NEAR_ZERO_RAW) begin
        if (o < -h || o > h) return 0;
      end else begin
        a = clamp_q(((-h - o) * 64'sd1073741824) / d);
        b = clamp_q(((h - o) * 64'sd1073741824) / d);
        if (a > b) begin
          s = a; a = b; b = s;
        end
        if (a > lo) lo = a;
        if (b < hi) hi = b;
        if (lo > hi) return 0;
      end
    end
    return hi >= 0 && lo <= longint'(maxd);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        hit_q.push_back(ray_hits('{in_origin_x, in_origin_y, in_origin_z},
                                 '{in_dir_x, in_dir_y, in_dir_z},
                                 '{in_half_x, in_half_y, in_half_z}, in_max_dist));
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) report_mismatch("word with none expected");
        else begin
          bit e;
          e = hit_q.pop_front();
          if (out_hit !== e) report_mismatch($sformatf("hit %b expected %b", out_hit, e));
        end
      end
    end
    pending = hit_q.size();
  end
endmodule

@@ bench/ray_box_slab_test_core_tb.sv @@
module ray_box_slab_test_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, out_hit;
  logic signed [31:0] ox, oy, oz, dx, dy, dz;
  logic [30:0] hx, hy, hz, md;
  int fail_count, pending, cycles;
  int in_gap, out_gap;
  bit calm;

  ray_box_slab_test_core u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_origin_x(ox), .in_origin_y(oy), .in_origin_z(oz),
    .in_dir_x(dx), .in_dir_y(dy), .in_dir_z(dz),
    .in_half_x(hx), .in_half_y(hy), .in_half_z(hz), .in_max_dist(md),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit));

  ray_box_slab_test_core_chk u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_origin_x(ox), .in_origin_y(oy), .in_origin_z(oz),
    .in_dir_x(dx), .in_dir_y(dy), .in_dir_z(dz),
    .in_half_x(hx), .in_half_y(hy), .in_half_z(hz), .in_max_dist(md),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("ray_box_slab_test_core test failed");
        $finish;
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (!rst_n || calm) out_stall <= 0;
    else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_gap <= $urandom_range(0, 7);
      out_stall <= 1;
    end else out_stall <= 0;
  end

  function automatic logic signed [31:0] rnd_dir();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 10737) * ($urandom_range(0, 1) ? 1 : -1);
      1: return $urandom();
      2: return ($urandom_range(0, 1) ? 32'sd10738 : -32'sd10738) + $urandom_range(0, 3) - 1;
      default: return $signed($urandom() >> $urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_pos();
    if ($urandom_range(0, 5) == 0) return $urandom();
    return $signed($urandom()) >>> $urandom_range(8, 14);
  endfunction

  function automatic logic [30:0] rnd_len();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 31'($urandom());
      default: return 31'($urandom() >> $urandom_range(9, 16));
    endcase
  endfunction

  task automatic send_ray(logic signed [31:0] a, b, c, d, e, f,
                          logic [30:0] g, h, i, j);
    if (!calm) begin
      while ($urandom_range(0, 4) == 0) begin
        in_gap = $urandom_range(1, 8);
        in_valid <= 0;
        repeat (in_gap) @(posedge clk);
      end
    end
    in_valid <= 1;
    ox <= a; oy <= b; oz <= c; dx <= d; dy <= e; dz <= f;
    hx <= g; hy <= h; hz <= i; md <= j;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    rst_n = 0; in_valid = 0; calm = 0; out_gap = 0; out_stall = 0;
    ox = 0; oy = 0; oz = 0; dx = 0; dy = 0; dz = 0;
    hx = 0; hy = 0; hz = 0; md = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed corners
    send_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_ray(-32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh4000_0000, 0, 0,
             31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    send_ray(-32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, 0, 0, 0, 0, 31'h7fff_ffff);
    send_ray(32'sh7fff_ffff, 0, 0, -32'sh8000_0000, 0, 0, 0, 0, 0, 31'h7fff_ffff);
    send_ray(-32'sh5_0000, 0, 0, 32'sh4000_0000, 0, 0,
             31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h3_ffff);
    send_ray(-32'sh5_0000, 0, 0, 32'sh4000_0000, 0, 0,
             31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h4_0000);
    send_ray(-32'sh5_0000, 0, 0, -32'sh4000_0000, 0, 0,
             31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h10_0000);
    send_ray(32'sh1_0000, 0, 0, 10737, 0, 0, 31'h1_0000, 1, 1, 5);
    send_ray(32'sh1_0001, 0, 0, -10737, 0, 0, 31'h1_0000, 1, 1, 5);
    send_ray(32'sh1_0001, 0, 0, 10738, 0, 0, 31'h1_0000, 1, 1, 31'h7fff_ffff);
    send_ray(32'sh1_0001, 0, 0, -10738, 0, 0, 31'h1_0000, 1, 1, 31'h7fff_ffff);
    send_ray(0, 0, 0, 32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000, 0, 0, 0, 0);
    send_ray(32'sh2_0000, 32'sh2_0000, 0, -32'sh4000_0000, -32'sh2000_0000, 0,
             31'h1_0000, 31'h1_0000, 31'h1_0000, 31'h7fff_ffff);
    send_ray(-1, -1, -1, -1, -1, -1, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 0);
    // random rays, mostly aimed near the box
    for (int n = 0; n < 500; n++) begin
      logic signed [31:0] r[6];
      logic [30:0] l[4];
      if (n == 440) calm = 1;
      for (int k = 0; k < 3; k++) begin
        r[k] = rnd_pos();
        r[k + 3] = rnd_dir();
      end
      for (int k = 0; k < 4; k++) l[k] = rnd_len();
      if ($urandom_range(0, 1)) for (int k = 0; k < 3; k++)
        r[k + 3] = (l[k] - r[k]) >>> 1;
      send_ray(r[0], r[1], r[2], r[3], r[4], r[5], l[0], l[1], l[2], l[3]);
    end
    in_valid <= 0;
    while (pending > 0) @(posedge clk);
    repeat (2 * rbs_pkg::PIPE_LAT) @(posedge clk);
    if (fail_count == 0) $display("ray_box_slab_test_core test passed");
    else $display("ray_box_slab_test_core test failed");
    $finish;
  end
endmodule

@@ ray_box_slab_test_core.f @@
design/rbs_pkg.sv
design/rbs_div_pipe.sv
design/rbs_axis_lane.sv
design/rbs_merge.sv
design/ray_box_slab_test_core.sv
bench/ray_box_slab_test_core_chk.sv
bench/ray_box_slab_test_core_tb.sv
